>>> design/isnb_pkg.sv
package isnb_pkg;
    localparam int MAX_SRC_WIDTH  = 512;
    localparam int MAX_SRC_HEIGHT = 512;
    localparam int MAX_DST_DIM    = 1024;
    localparam int FRAC_BITS      = 12;

    localparam int SW_W   = 10;
    localparam int DW_W   = 11;
    localparam int POS_W  = 10;
    localparam int PIX_W  = 8;
    localparam int STEP_W = 22;
    localparam int PROD_W = POS_W + STEP_W;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 3;
    localparam int BANK_A = 16;

    localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_INTERP     = 3'd4;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;
endpackage

>>> design/isnb_in_if.sv
interface isnb_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic [7:0] pixel_in;
    modport source (output valid, action, pos_x, pos_y, pixel_in, input ready);
    modport sink (input valid, action, pos_x, pos_y, pixel_in, output ready);
endinterface

>>> design/isnb_out_if.sv
interface isnb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       bad_coord;
    modport source (output valid, pixel_out, bad_coord, input ready);
    modport sink (input valid, pixel_out, bad_coord, output ready);
endinterface

>>> design/image_scaler_nearest_bilinear.sv
// An accepted beat passes through registers r1 to r6; a compute beat's result comes from r6.
// Throughput: one beat per cycle while the sink takes results and no register write or step
// division is under way; the pipeline holds as a whole when the output register is full
// and not taken. A register write to indices 0 to 4 starts a step division.
// Reset (i_rst_n low, synchronous) restores register defaults and steps of 4097 and empties
// the pipeline; the frame store is not cleared.
module image_scaler_nearest_bilinear (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [10:0]            i_cfg_data,
    isnb_in_if.sink                i_in,
    isnb_out_if.source             o_out
);
    import isnb_pkg::*;

    logic [SW_W-1:0] r_sw, r_sh;
    logic [DW_W-1:0] r_dw, r_dh;
    logic            r_mode;
    logic [SW_W-1:0] sw_e, sh_e;
    logic [DW_W-1:0] dw_e, dh_e;

    always_comb begin
        sw_e = (r_sw < SW_W'(2)) ? SW_W'(2) :
               (r_sw > SW_W'(MAX_SRC_WIDTH)) ? SW_W'(MAX_SRC_WIDTH) : r_sw;
        sh_e = (r_sh < SW_W'(2)) ? SW_W'(2) :
               (r_sh > SW_W'(MAX_SRC_HEIGHT)) ? SW_W'(MAX_SRC_HEIGHT) : r_sh;
        dw_e = (r_dw < DW_W'(1)) ? DW_W'(1) :
               (r_dw > DW_W'(MAX_DST_DIM)) ? DW_W'(MAX_DST_DIM) : r_dw;
        dh_e = (r_dh < DW_W'(1)) ? DW_W'(1) :
               (r_dh > DW_W'(MAX_DST_DIM)) ? DW_W'(MAX_DST_DIM) : r_dh;
    end

    // step division
    logic [4:0]        r_cnt;
    logic [STEP_W-1:0] r_qx, r_qy, n_qx, n_qy;
    logic [DW_W-1:0]   r_rx, r_ry, n_rx, n_ry;
    logic [STEP_W-1:0] r_stx, r_sty;
    logic [DW_W:0]     tx, ty;
    logic              cfg_hit;

    assign cfg_hit = i_cfg_we && (i_cfg_idx <= REG_INTERP);

    always_comb begin
        tx = {r_rx, r_qx[STEP_W-1]};
        ty = {r_ry, r_qy[STEP_W-1]};
        if (tx >= {1'b0, dw_e}) begin
            n_rx = DW_W'(tx - {1'b0, dw_e});
            n_qx = {r_qx[STEP_W-2:0], 1'b1};
        end else begin
            n_rx = tx[DW_W-1:0];
            n_qx = {r_qx[STEP_W-2:0], 1'b0};
        end
        if (ty >= {1'b0, dh_e}) begin
            n_ry = DW_W'(ty - {1'b0, dh_e});
            n_qy = {r_qy[STEP_W-2:0], 1'b1};
        end else begin
            n_ry = ty[DW_W-1:0];
            n_qy = {r_qy[STEP_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw   <= SW_W'(512);
            r_sh   <= SW_W'(512);
            r_dw   <= DW_W'(512);
            r_dh   <= DW_W'(512);
            r_mode <= 1'b0;
            r_cnt  <= '0;
            r_stx  <= STEP_W'(4097);
            r_sty  <= STEP_W'(4097);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SRC_WIDTH:  r_sw   <= i_cfg_data[SW_W-1:0];
                    REG_SRC_HEIGHT: r_sh   <= i_cfg_data[SW_W-1:0];
                    REG_DST_WIDTH:  r_dw   <= i_cfg_data;
                    REG_DST_HEIGHT: r_dh   <= i_cfg_data;
                    REG_INTERP:     r_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_cnt <= 5'd23;
            end else if (r_cnt == 5'd23) begin
                r_cnt <= 5'd22;
            end else if (r_cnt != 5'd0) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_stx <= n_qx + STEP_W'(1);
                    r_sty <= n_qy + STEP_W'(1);
                end
            end
        end
    end

    // load the dividends once the new register values are in place
    always_ff @(posedge i_clk) begin
        if (r_cnt == 5'd23) begin
            r_qx <= STEP_W'({sw_e, {FRAC_BITS{1'b0}}});
            r_qy <= STEP_W'({sh_e, {FRAC_BITS{1'b0}}});
            r_rx <= '0;
            r_ry <= '0;
        end else if (r_cnt != 5'd0) begin
            r_qx <= n_qx;
            r_qy <= n_qy;
            r_rx <= n_rx;
            r_ry <= n_ry;
        end
    end

    // pipeline
    logic en;
    logic [5:0] r_v;
    assign en = !(r_v[5] && !o_out.ready);
    assign i_in.ready = en && (r_cnt == 5'd0) && !i_cfg_we;

    logic             r1_act;
    logic [POS_W-1:0] r1_px, r1_py;
    logic [PIX_W-1:0] r1_pin;

    logic             r2_act, r2_bad, r2_eq;
    logic [POS_W-1:0] r2_px, r2_py;
    logic [PIX_W-1:0] r2_pin;
    logic [PROD_W-1:0] r2_x, r2_y;

    logic             r3_cmp, r3_bad, r3_bl;
    logic             r3_rp, r3_cp;
    logic [FRAC_BITS:0] r3_cx, r3_fx, r3_cy, r3_fy;
    logic [PIX_W-1:0] r_rd [4];
    logic [PIX_W-1:0] r_mem [4][1 << BANK_A];

    logic [POS_W-1:0] row, col;
    logic [PROD_W-FRAC_BITS-1:0] xi, yi;
    logic [BANK_A-1:0] raddr [4];
    logic [BANK_A-1:0] waddr;
    logic             wr, bl;
    logic [POS_W:0]   rsum0, rsum1, csum0, csum1;

    always_comb begin
        xi = r2_x[PROD_W-1:FRAC_BITS];
        yi = r2_y[PROD_W-1:FRAC_BITS];
        bl = r_mode && !r2_eq;
        if (r2_eq) begin
            col = r2_px;
            row = r2_py;
        end else begin
            col = (xi < (PROD_W-FRAC_BITS)'(sw_e - SW_W'(2))) ? xi[POS_W-1:0]
                                                               : (sw_e - SW_W'(2));
            row = (yi < (PROD_W-FRAC_BITS)'(sh_e - SW_W'(1))) ? yi[POS_W-1:0]
                                                               : (sh_e - SW_W'(1));
            if (bl && row == (sh_e - SW_W'(1))) begin
                row = row - POS_W'(1);
            end
        end
        rsum0 = {1'b0, row} + (POS_W+1)'(row[0]);
        rsum1 = {1'b0, row} + (POS_W+1)'(!row[0]);
        csum0 = {1'b0, col} + (POS_W+1)'(col[0]);
        csum1 = {1'b0, col} + (POS_W+1)'(!col[0]);
        raddr[0] = {rsum0[8:1], csum0[8:1]};
        raddr[1] = {rsum0[8:1], csum1[8:1]};
        raddr[2] = {rsum1[8:1], csum0[8:1]};
        raddr[3] = {rsum1[8:1], csum1[8:1]};
        waddr = {r2_py[8:1], r2_px[8:1]};
        wr = r_v[1] && (r2_act == ACT_LOAD) && (r2_px < sw_e) && (r2_py < sh_e);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int b = 0; b < 4; b++) begin
                if (wr && {r2_py[0], r2_px[0]} == 2'(b)) begin
                    r_mem[b][waddr] <= r2_pin;
                end
                r_rd[b] <= r_mem[b][raddr[b]];
            end
        end
    end

    logic [PIX_W-1:0] p0, p1, p2, p3;
    always_comb begin
        p0 = r_rd[{r3_rp, r3_cp}];
        p1 = r_rd[{r3_rp, !r3_cp}];
        p2 = r_rd[{!r3_rp, r3_cp}];
        p3 = r_rd[{!r3_rp, !r3_cp}];
    end

    logic             r4_cmp, r4_bad, r4_bl;
    logic [PIX_W-1:0] r4_near;
    logic [20:0]      r4_h0, r4_h1;
    logic [FRAC_BITS:0] r4_cy, r4_fy;

    logic             r5_cmp, r5_bad, r5_bl;
    logic [PIX_W-1:0] r5_near;
    logic [33:0]      r5_a, r5_b;

    logic [PIX_W-1:0] r6_pix;
    logic             r6_bad;
    logic [34:0]      acc;
    logic [PIX_W-1:0] bl_pix;

    always_comb begin
        acc = {1'b0, r5_a} + {1'b0, r5_b};
        bl_pix = (acc[34:2*FRAC_BITS] > 11'd255) ? 8'hFF : acc[2*FRAC_BITS +: PIX_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[4:3], r_v[2] && r3_cmp, r_v[1:0], i_in.valid && i_in.ready};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_act <= i_in.action;
            r1_px  <= i_in.pos_x;
            r1_py  <= i_in.pos_y;
            r1_pin <= i_in.pixel_in;

            r2_act <= r1_act;
            r2_px  <= r1_px;
            r2_py  <= r1_py;
            r2_pin <= r1_pin;
            r2_bad <= ({1'b0, r1_px} >= dw_e) || ({1'b0, r1_py} >= dh_e);
            r2_eq  <= ({1'b0, sw_e} == dw_e) && ({1'b0, sh_e} == dh_e);
            r2_x   <= r1_px * r_stx;
            r2_y   <= r1_py * r_sty;

            r3_cmp <= r_v[1] && (r2_act == ACT_COMPUTE);
            r3_bad <= r2_bad;
            r3_bl  <= bl;
            r3_rp  <= row[0];
            r3_cp  <= col[0];
            r3_fx  <= {1'b0, r2_x[FRAC_BITS-1:0]};
            r3_cx  <= (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, r2_x[FRAC_BITS-1:0]};
            r3_fy  <= {1'b0, r2_y[FRAC_BITS-1:0]};
            r3_cy  <= (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, r2_y[FRAC_BITS-1:0]};

            r4_bad  <= r3_bad;
            r4_bl   <= r3_bl;
            r4_near <= p0;
            r4_h0   <= 21'(p0) * 21'(r3_cx) + 21'(p1) * 21'(r3_fx);
            r4_h1   <= 21'(p2) * 21'(r3_cx) + 21'(p3) * 21'(r3_fx);
            r4_cy   <= r3_cy;
            r4_fy   <= r3_fy;

            r5_bad  <= r4_bad;
            r5_bl   <= r4_bl;
            r5_near <= r4_near;
            r5_a    <= r4_h0 * r4_cy;
            r5_b    <= r4_h1 * r4_fy;

            r6_bad <= r5_bad;
            r6_pix <= r5_bad ? 8'h00 : (r5_bl ? bl_pix : r5_near);
        end
    end

    assign r4_cmp = 1'b0;
    assign r5_cmp = 1'b0;
    assign o_out.valid     = r_v[5] || (r4_cmp && r5_cmp);
    assign o_out.pixel_out = r6_pix;
    assign o_out.bad_coord = r6_bad;
endmodule

>>> dv/tb_image_scaler_nearest_bilinear.sv
module tb_image_scaler_nearest_bilinear;
    import isnb_pkg::*;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int DRAIN_CYCLES = 12;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             bad;
    } scaled_pix_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    isnb_in_if  in_bus();
    isnb_out_if out_bus();

    image_scaler_nearest_bilinear dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    logic [PIX_W-1:0] src_pixels [STORE_DEPTH];
    bit               src_known  [STORE_DEPTH];
    int unsigned      reg_sw, reg_sh, reg_dw, reg_dh, reg_mode;
    longint unsigned  step_x, step_y;
    scaled_pix_t      pending_pix [$];
    int               errors;
    longint           cycles;
    bit               steady_flow;
    int               sink_hold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned eff_sw();
        return clamp(reg_sw, 2, MAX_SRC_WIDTH);
    endfunction
    function automatic int unsigned eff_sh();
        return clamp(reg_sh, 2, MAX_SRC_HEIGHT);
    endfunction
    function automatic int unsigned eff_dw();
        return clamp(reg_dw, 1, MAX_DST_DIM);
    endfunction
    function automatic int unsigned eff_dh();
        return clamp(reg_dh, 1, MAX_DST_DIM);
    endfunction

    function automatic void recalc_steps();
        step_x = ((longint'(eff_sw())) << FRAC_BITS) / eff_dw() + 1;
        step_y = ((longint'(eff_sh())) << FRAC_BITS) / eff_dh() + 1;
    endfunction

    // source window of one destination pixel: top-left corner and fractions
    function automatic bit map_to_source(input int unsigned x, input int unsigned y,
                                         output int unsigned row, output int unsigned col,
                                         output longint unsigned fx,
                                         output longint unsigned fy);
        longint unsigned xs, ys;
        bit copy;
        copy = (eff_sw() == eff_dw()) && (eff_sh() == eff_dh());
        xs = longint'(x) * step_x;
        ys = longint'(y) * step_y;
        fx = xs & ((1 << FRAC_BITS) - 1);
        fy = ys & ((1 << FRAC_BITS) - 1);
        col = ((xs >> FRAC_BITS) < eff_sw() - 2) ? (xs >> FRAC_BITS) : eff_sw() - 2;
        row = ((ys >> FRAC_BITS) < eff_sh() - 1) ? (ys >> FRAC_BITS) : eff_sh() - 1;
        if (copy) begin
            col = x;
            row = y;
        end else if (reg_mode != 0 && row + 1 >= eff_sh()) begin
            row--;
        end
        return copy;
    endfunction

    function automatic scaled_pix_t scale_pixel(int unsigned x, int unsigned y);
        scaled_pix_t r;
        int unsigned row, col;
        longint unsigned fx, fy, cx, cy, acc;
        bit copy;
        r = '0;
        if (x >= eff_dw() || y >= eff_dh()) begin
            r.bad = 1'b1;
            return r;
        end
        copy = map_to_source(x, y, row, col, fx, fy);
        if (copy || reg_mode == 0) begin
            r.pixel = src_pixels[row * MAX_SRC_WIDTH + col];
            return r;
        end
        cx = (1 << FRAC_BITS) - fx;
        cy = (1 << FRAC_BITS) - fy;
        acc = (src_pixels[row * MAX_SRC_WIDTH + col] * cx
              + src_pixels[row * MAX_SRC_WIDTH + col + 1] * fx) * cy
            + (src_pixels[(row + 1) * MAX_SRC_WIDTH + col] * cx
              + src_pixels[(row + 1) * MAX_SRC_WIDTH + col + 1] * fx) * fy;
        acc = acc >> (2 * FRAC_BITS);
        r.pixel = (acc > 255) ? 8'hFF : acc[7:0];
        return r;
    endfunction

    // one beat on the input channel; returns at the falling edge after acceptance
    task automatic send_beat(logic act, int unsigned x, int unsigned y, logic [7:0] value);
        int gap;
        gap = steady_flow ? 0 : (($urandom_range(99) < 6) ? $urandom_range(1, 4) : 0);
        if (gap > 0) begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid    = 1'b1;
        in_bus.action   = act;
        in_bus.pos_x    = x[POS_W-1:0];
        in_bus.pos_y    = y[POS_W-1:0];
        in_bus.pixel_in = value;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        if (act == ACT_LOAD) begin
            if (x < eff_sw() && y < eff_sh()) begin
                src_pixels[y * MAX_SRC_WIDTH + x] = value;
                src_known[y * MAX_SRC_WIDTH + x]  = 1'b1;
            end
        end else begin
            pending_pix.push_back(scale_pixel(x, y));
        end
        @(negedge i_clk);
    endtask

    // load any source pixel the compute would read that is still unknown, then send the compute beat
    task automatic compute_pixel(int unsigned x, int unsigned y);
        int unsigned row, col;
        longint unsigned fx, fy;
        int span;
        bit copy;
        if (x < eff_dw() && y < eff_dh()) begin
            copy = map_to_source(x, y, row, col, fx, fy);
            span = (copy || reg_mode == 0) ? 1 : 2;
            for (int dr = 0; dr < span; dr++)
                for (int dc = 0; dc < span; dc++)
                    if (!src_known[(row + dr) * MAX_SRC_WIDTH + col + dc])
                        send_beat(ACT_LOAD, col + dc, row + dr, 8'($urandom));
        end
        send_beat(ACT_COMPUTE, x, y, 8'($urandom));
    endtask

    task automatic drain();
        in_bus.valid = 1'b0;
        while (pending_pix.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_SRC_WIDTH:  reg_sw = value & 10'h3FF;
            REG_SRC_HEIGHT: reg_sh = value & 10'h3FF;
            REG_DST_WIDTH:  reg_dw = value & 11'h7FF;
            REG_DST_HEIGHT: reg_dh = value & 11'h7FF;
            REG_INTERP:     reg_mode = value & 1;
            default: ;
        endcase
        recalc_steps();
    endtask

    task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned dw,
                                int unsigned dh, int unsigned mode);
        drain();
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_INTERP, mode);
    endtask

    task automatic random_computes(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: send_beat(ACT_LOAD, $urandom_range(1023), $urandom_range(1023),
                             8'($urandom));
                1: compute_pixel($urandom_range(1023), $urandom_range(1023));
                default: compute_pixel($urandom_range(eff_dw() - 1),
                                       $urandom_range(eff_dh() - 1));
            endcase
        end
    endtask

    task automatic test_copy_at_reset();
        send_beat(ACT_LOAD, 0, 0, 8'hFF);
        send_beat(ACT_LOAD, 511, 511, 8'h00);
        send_beat(ACT_LOAD, 1023, 5, 8'hAA);
        send_beat(ACT_LOAD, 5, 1023, 8'h55);
        send_beat(ACT_COMPUTE, 0, 0, 8'h00);
        send_beat(ACT_COMPUTE, 511, 511, 8'h00);
        send_beat(ACT_COMPUTE, 1023, 0, 8'h00);
        send_beat(ACT_COMPUTE, 0, 512, 8'h00);
    endtask

    task automatic test_corners();
        set_geometry(5, 4, 11, 9, 1);
        compute_pixel(0, 0);
        compute_pixel(10, 8);
        compute_pixel(10, 0);
        compute_pixel(0, 8);
        compute_pixel(11, 3);
        compute_pixel(3, 9);
        set_geometry(5, 4, 11, 9, 0);
        compute_pixel(10, 8);
        compute_pixel(4, 4);
        set_geometry(6, 6, 6, 6, 1);
        compute_pixel(5, 5);
        compute_pixel(2, 3);
        set_geometry(9, 7, 3, 2, 1);
        compute_pixel(2, 1);
        compute_pixel(1, 0);
    endtask

    task automatic test_extreme_sizes();
        set_geometry(2, 2, 1024, 1024, 1);
        random_computes(25);
        set_geometry(512, 512, 1, 1, 1);
        compute_pixel(0, 0);
        compute_pixel(1, 0);
        set_geometry(0, 1023, 2047, 0, 0);
        random_computes(20);
        set_geometry(1023, 0, 0, 2047, 1);
        random_computes(20);
        set_geometry(512, 300, 1024, 77, 1);
        random_computes(10);
    endtask

    task automatic test_random_geometry();
        for (int p = 0; p < 4; p++) begin
            if ($urandom_range(3) == 0)
                set_geometry($urandom_range(1023), $urandom_range(1023),
                             $urandom_range(2047), $urandom_range(2047),
                             $urandom_range(1));
            else
                set_geometry($urandom_range(2, 16), $urandom_range(2, 16),
                             $urandom_range(1, 40), $urandom_range(1, 40),
                             $urandom_range(1));
            random_computes(10);
        end
    endtask

    task automatic test_backpressure();
        set_geometry(8, 8, 13, 5, 1);
        random_computes(10);
        drain();
        sink_hold = 300;
        for (int i = 0; i < 40; i++)
            compute_pixel($urandom_range(12), $urandom_range(4));
        drain();
    endtask

    task automatic test_full_rate();
        set_geometry(16, 12, 7, 20, 0);
        steady_flow = 1'b1;
        random_computes(40);
        drain();
        steady_flow = 1'b0;
    endtask

    // result sink
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                out_bus.ready = 1'b0;
                sink_hold--;
            end else if (steady_flow) begin
                out_bus.ready = 1'b1;
            end else begin
                out_bus.ready = ($urandom_range(99) >= 15);
            end
        end
    end

    always @(posedge i_clk) begin
        scaled_pix_t want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_pix.size() == 0) begin
                errors++;
                $display("%0t: unexpected result pixel %0d bad %0b", $time,
                         out_bus.pixel_out, out_bus.bad_coord);
            end else begin
                want = pending_pix.pop_front();
                if (out_bus.pixel_out !== want.pixel) begin
                    errors++;
                    $display("%0t: pixel_out expected %0d actual %0d", $time,
                             want.pixel, out_bus.pixel_out);
                end
                if (out_bus.bad_coord !== want.bad) begin
                    errors++;
                    $display("%0t: bad_coord expected %0b actual %0b", $time,
                             want.bad, out_bus.bad_coord);
                end
            end
        end
    end

    initial begin
        errors      = 0;
        cycles      = 0;
        steady_flow = 1'b0;
        sink_hold   = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_SRC_WIDTH;
        i_cfg_data  = '0;
        in_bus.valid    = 1'b0;
        in_bus.action   = ACT_LOAD;
        in_bus.pos_x    = '0;
        in_bus.pos_y    = '0;
        in_bus.pixel_in = '0;
        reg_sw = 512;
        reg_sh = 512;
        reg_dw = 512;
        reg_dh = 512;
        reg_mode = 0;
        recalc_steps();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_copy_at_reset();
        test_corners();
        test_extreme_sizes();
        test_backpressure();
        test_full_rate();
        test_random_geometry();
        drain();

        if (errors == 0 && pending_pix.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> filelist.f
design/isnb_pkg.sv
design/isnb_in_if.sv
design/isnb_out_if.sv
design/image_scaler_nearest_bilinear.sv
dv/tb_image_scaler_nearest_bilinear.sv
